// ===== hw/rtl/servo_reply_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Servo reply frame parser assertion macros
// Checks are clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERVO_REPLY_FRAME_PARSER_MACROS_SVH
`define SERVO_REPLY_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

`define SRFP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("srfp check failed");

`define SRFP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srfp check failed");

`else

`define SRFP_ASSERT_ALWAYS(lbl, expr)

`define SRFP_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/srfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_pkg
// Shared constants, types and register codes of the servo reply frame parser.
// ----------------------------------------------------------------------------
package srfp_pkg;

    localparam int PAYLOAD_DEPTH = 5;
    localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
    localparam int IDX_W         = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]       LEN_FLOOR = 8'd3;
    localparam logic [7:0]       LEN_CAP   = 8'(PAYLOAD_DEPTH + 2);
    localparam logic [7:0]       LEN_OVHD  = 8'd2;
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    localparam logic [7:0] HEADER_RST  = 8'h55;
    localparam logic [2:0] MIN_LEN_RST = 3'd3;
    localparam logic [2:0] MAX_LEN_RST = 3'd7;

    localparam logic [1:0] CFG_HEADER  = 2'd0;
    localparam logic [1:0] CFG_MIN_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN = 2'd2;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef enum logic [2:0] {
        S_HUNT,
        S_HDR,
        S_ID,
        S_LEN,
        S_DATA
    } t_front_state;

    typedef struct packed {
        logic [PAYLOAD_DEPTH-1:0][7:0] payload;
        logic [CNT_W-1:0]              count;
        logic                          bad;
        logic [7:0]                    id;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// ===== hw/rtl/srfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_front
// Hunts for the header pair, checks length and checksum, and hands each
// completed frame to the frame queue.
// ----------------------------------------------------------------------------
module srfp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  srfp_pkg::t_fifo_status i_fifo,
    output logic                  o_push,
    output srfp_pkg::t_frame      o_frame
);
    import srfp_pkg::*;

    t_front_state r_state, n_state;

    logic [7:0]       r_hdr;
    logic [2:0]       r_min;
    logic [2:0]       r_max;
    logic [7:0]       r_sum;
    logic [7:0]       r_id;
    logic [CNT_W-1:0] r_npay;
    logic [CNT_W-1:0] r_pos;
    logic [7:0]       r_pay [PAYLOAD_DEPTH];

    logic             w_acc;
    logic             w_is_chk;
    logic             w_len_ok;
    logic [7:0]       w_lo;
    logic [7:0]       w_hi;
    logic [CNT_W-1:0] w_npay;

    assign o_ready  = !i_fifo.full;
    assign w_acc    = i_valid && o_ready;
    assign w_is_chk = (r_pos == r_npay);
    assign w_lo     = ({5'd0, r_min} < LEN_FLOOR) ? LEN_FLOOR : {5'd0, r_min};
    assign w_hi     = ({5'd0, r_max} > LEN_CAP) ? LEN_CAP : {5'd0, r_max};
    assign w_len_ok = (i_byte >= w_lo) && (i_byte <= w_hi);
    assign w_npay   = CNT_W'(i_byte - LEN_OVHD);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_HUNT: begin
                if (w_acc && i_byte == r_hdr) n_state = S_HDR;
            end
            S_HDR: begin
                if (w_acc) n_state = (i_byte == r_hdr) ? S_ID : S_HUNT;
            end
            S_ID: begin
                if (w_acc) n_state = S_LEN;
            end
            S_LEN: begin
                if (w_acc) n_state = w_len_ok ? S_DATA : S_HUNT;
            end
            S_DATA: begin
                if (w_acc && w_is_chk) n_state = S_HUNT;
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_comb begin
        o_push        = 1'b0;
        o_frame.id    = r_id;
        o_frame.count = r_npay;
        o_frame.bad   = (~r_sum != i_byte);
        for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
            o_frame.payload[i] = r_pay[i];
        end
        case (r_state)
            S_DATA: o_push = w_acc && w_is_chk;
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
            r_hdr   <= HEADER_RST;
            r_min   <= MIN_LEN_RST;
            r_max   <= MAX_LEN_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEADER:  r_hdr <= i_cfg_data;
                    CFG_MIN_LEN: r_min <= i_cfg_data[2:0];
                    CFG_MAX_LEN: r_max <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            case (r_state)
                S_ID: begin
                    r_id  <= i_byte;
                    r_sum <= i_byte;
                end
                S_LEN: begin
                    r_npay <= w_npay;
                    r_sum  <= r_sum + i_byte;
                    r_pos  <= '0;
                end
                S_DATA: begin
                    if (!w_is_chk) begin
                        for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
                            if (r_pos == CNT_W'(i)) r_pay[i] <= i_byte;
                        end
                        r_sum <= r_sum + i_byte;
                        r_pos <= r_pos + CNT_ONE;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/srfp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_fifo
// Two-entry queue of completed frames between the parser and the emitter.
// ----------------------------------------------------------------------------
module srfp_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  srfp_pkg::t_frame       i_frame,
    input  logic                   i_pop,
    output srfp_pkg::t_frame       o_frame,
    output srfp_pkg::t_fifo_status o_status
);
    import srfp_pkg::*;

    t_frame                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_status.full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_frame        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_frame;
    end

endmodule

// ===== hw/rtl/srfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_back
// Walks the frame at the queue head and emits one result per cycle into an
// output register while the queue is not empty and the output is not stalled.
// ----------------------------------------------------------------------------
module srfp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  srfp_pkg::t_frame       i_frame,
    input  srfp_pkg::t_fifo_status i_fifo,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_id,
    output logic [7:0]             o_payload,
    output logic                   o_status,
    output logic                   o_last
);
    import srfp_pkg::*;

    logic             r_valid;
    logic [7:0]       r_id;
    logic [7:0]       r_payload;
    logic             r_status;
    logic             r_last;
    logic [CNT_W-1:0] r_k;

    logic             w_load;
    logic             w_take;
    logic             w_last;
    logic [CNT_W-1:0] w_k_next;

    assign w_k_next = r_k + CNT_ONE;
    assign w_last   = i_frame.bad || (w_k_next == i_frame.count);
    assign w_load   = !r_valid || i_ready;
    assign w_take   = w_load && !i_fifo.empty;
    assign o_pop    = w_take && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (w_take) begin
            r_valid <= 1'b1;
            r_k     <= w_last ? '0 : w_k_next;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_id      <= i_frame.id;
            r_payload <= i_frame.bad ? 8'd0 : i_frame.payload[r_k[IDX_W-1:0]];
            r_status  <= i_frame.bad ? STATUS_BAD : STATUS_GOOD;
            r_last    <= w_last;
        end
    end

    assign o_valid   = r_valid;
    assign o_id      = r_id;
    assign o_payload = r_payload;
    assign o_status  = r_status;
    assign o_last    = r_last;

endmodule

// ===== hw/rtl/servo_reply_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_reply_frame_parser
// Receives servo reply bytes on the slave stream and emits the command and
// parameter bytes of each frame whose checksum matches, or one error result.
//
// Input: one received byte per transfer; a byte is taken every cycle while
// the two-entry frame queue has room.
// Output: tdata = servo id (bits 7:0) and payload byte (bits 15:8), tuser =
// checksum status (1 = error, payload zero), tlast marks the final result of
// a frame. A good frame with length byte L yields L-2 results, one per cycle
// while tready is high.
// A frame is queued when its checksum byte transfers, and its first result
// then reaches tvalid through the output register.
// Config: write header byte, min and max length through i_cfg_* while idle.
// Reset: hunting for the header, queue empty, registers at their defaults.
// Stall: the output register holds while tready is low; the emitter stops,
// the queue fills, and tready on the input drops once two frames wait.
// ----------------------------------------------------------------------------
`include "servo_reply_frame_parser_macros.svh"

module servo_reply_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] servo_id, [15:8] payload_byte
    output logic        o_m_axis_tuser,   // [0] status
    output logic        o_m_axis_tlast
);
    import srfp_pkg::*;

    t_frame       w_push_frame;
    t_frame       w_head_frame;
    t_fifo_status w_fifo;
    logic         w_push;
    logic         w_pop;
    logic [7:0]   w_id;
    logic [7:0]   w_payload;

    srfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_fifo     (w_fifo),
        .o_push     (w_push),
        .o_frame    (w_push_frame)
    );

    srfp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_frame  (w_push_frame),
        .i_pop    (w_pop),
        .o_frame  (w_head_frame),
        .o_status (w_fifo)
    );

    srfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (w_head_frame),
        .i_fifo    (w_fifo),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_id      (w_id),
        .o_payload (w_payload),
        .o_status  (o_m_axis_tuser),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_payload, w_id};

    `SRFP_ASSERT_IMPL(a_push_has_room, w_push, !w_fifo.full)
    `SRFP_ASSERT_IMPL(a_pop_has_frame, w_pop, !w_fifo.empty)
    `SRFP_ASSERT_IMPL(a_error_is_last, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast)
    `SRFP_ASSERT_IMPL(a_error_no_data, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[15:8] == 8'd0)

endmodule
